// File: src/cdv_pkg.sv
`default_nettype none

package cdv_pkg;

    // Digit steps of the root and quotient cell rows
    localparam int unsigned ROOT_STEPS = 32;
    localparam int unsigned QUOT_STEPS = 32;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MU_E   = 3'd0,
        CFG_MU_H   = 3'd1,
        CFG_VS_E   = 3'd2,
        CFG_VS_H   = 3'd3,
        CFG_HF_E   = 3'd4,
        CFG_HF_H   = 3'd5,
        CFG_B2_THR = 3'd6
    } t_cfg_idx;

    localparam logic [31:0] RST_MU_E   = 32'd2638828;
    localparam logic [31:0] RST_MU_H   = 32'd2308975;
    localparam logic [31:0] RST_VS_E   = 32'd111669150;
    localparam logic [31:0] RST_VS_H   = 32'd111669150;
    localparam logic [17:0] RST_HF_E   = 18'd65536;
    localparam logic [17:0] RST_HF_H   = 18'd65536;
    localparam logic [31:0] RST_B2_THR = 32'd1;

    localparam logic signed [39:0] VEL_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] VEL_MIN = -40'sh80_0000_0000;

    // Fields that travel with an item down the pipe
    typedef struct packed {
        logic             hole;
        logic             lowf;
        logic             vs0;
        logic [31:0]      m;
        logic [2:0][23:0] e;
        logic [2:0][20:0] b;
    } t_fld;

    typedef struct packed {
        t_fld             fld;
        logic [2:0][48:0] vl;
        logic [2:0][57:0] nv;
    } t_d2_side;

    // Shift right by s with rounding to nearest, ties away from zero
    function automatic logic signed [127:0] rnd_shr(input logic signed [127:0] p,
                                                    input int unsigned s);
        logic signed [127:0] t;
        t = p + (128'sd1 <<< (s - 1)) - 128'(p[127]);
        return t >>> s;
    endfunction

endpackage

`default_nettype wire

// File: src/cdv_sqrt_cell.sv
`default_nettype none

module cdv_sqrt_cell #(
    parameter int unsigned SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [63:0]   i_rad,
    input  wire logic [34:0]   i_rem,
    input  wire logic [31:0]   i_root,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [63:0]        o_rad,
    output logic [34:0]        o_rem,
    output logic [31:0]        o_root,
    output logic [SW-1:0]      o_side
);

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // Bring in the next two radicand bits and try one root bit
    always_comb begin
        rem_sh = {i_rem[32:0], i_rad[63:62]};
        trial  = {1'b0, i_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[61:0], 2'b00};
            o_rem  <= ge ? (rem_sh - trial) : rem_sh;
            o_root <= {i_root[30:0], ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: src/cdv_div_cell.sv
`default_nettype none

module cdv_div_cell #(
    parameter int unsigned DW = 34,
    parameter int unsigned SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [31:0]   i_nq,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [DW-1:0]      o_div,
    output logic [DW-1:0]      o_rem,
    output logic [31:0]        o_nq,
    output logic [SW-1:0]      o_side
);

    logic [DW:0] r2;
    logic [DW:0] rs;
    logic        ge;

    // One restoring step: numerator bits leave the top of nq, quotient bits enter below
    always_comb begin
        r2 = {i_rem, i_nq[31]};
        ge = (r2 >= {1'b0, i_div});
        rs = r2 - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_div  <= i_div;
            o_rem  <= ge ? rs[DW-1:0] : r2[DW-1:0];
            o_nq   <= {i_nq[30:0], ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: src/carrier_drift_velocity.sv
// Carrier drift velocity with saturated mobility and Hall deflection.
//
// Input channel: i_valid / o_stall with i_action (0 electron, 1 hole), the
// electric field i_e_x..z and the magnetic field i_b_x..z. A beat is taken on
// a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_vel_x..z, one beat per input beat,
// in input order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write registers only while no beat is in flight.
//
// Throughput is one beat per cycle while o_stall is low. From input beat to
// o_valid the path is a row of 32 square-root cells, two rows of 32 restoring
// divider cells (mobility and Hall prefactor), the multiply and rounding stages
// between them, and the output register.
// A synchronous reset empties the pipe and loads the register defaults.
// When the receiver stalls, the output beat holds and a skid register catches
// the beat behind it; o_stall then rises and the whole pipe holds until the
// skid register drains.
`default_nettype none

module carrier_drift_velocity (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_action,
    input  wire logic signed [23:0]              i_e_x,
    input  wire logic signed [23:0]              i_e_y,
    input  wire logic signed [23:0]              i_e_z,
    input  wire logic signed [20:0]              i_b_x,
    input  wire logic signed [20:0]              i_b_y,
    input  wire logic signed [20:0]              i_b_z,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [39:0]                   o_vel_x,
    output logic signed [39:0]                   o_vel_y,
    output logic signed [39:0]                   o_vel_z,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cdv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);

    localparam int unsigned FLD_W = $bits(cdv_pkg::t_fld);
    localparam int unsigned D2_W  = $bits(cdv_pkg::t_d2_side);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_mu_e, r_mu_h, r_vs_e, r_vs_h, r_thr;
    logic [17:0] r_hf_e, r_hf_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_e <= cdv_pkg::RST_MU_E;
            r_mu_h <= cdv_pkg::RST_MU_H;
            r_vs_e <= cdv_pkg::RST_VS_E;
            r_vs_h <= cdv_pkg::RST_VS_H;
            r_hf_e <= cdv_pkg::RST_HF_E;
            r_hf_h <= cdv_pkg::RST_HF_H;
            r_thr  <= cdv_pkg::RST_B2_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cdv_pkg::t_cfg_idx'(i_cfg_index))
                cdv_pkg::CFG_MU_E:   r_mu_e <= i_cfg_data;
                cdv_pkg::CFG_MU_H:   r_mu_h <= i_cfg_data;
                cdv_pkg::CFG_VS_E:   r_vs_e <= i_cfg_data;
                cdv_pkg::CFG_VS_H:   r_vs_h <= i_cfg_data;
                cdv_pkg::CFG_HF_E:   r_hf_e <= i_cfg_data[17:0];
                cdv_pkg::CFG_HF_H:   r_hf_h <= i_cfg_data[17:0];
                cdv_pkg::CFG_B2_THR: r_thr  <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe enable: the whole pipe holds while the skid register is full
    // ------------------------------------------------------------------
    logic r_skid_full;
    logic en;

    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    // ------------------------------------------------------------------
    // S1: squares of the field components, |B|^2 threshold test
    // ------------------------------------------------------------------
    logic signed [23:0] in_e [3];
    logic signed [20:0] in_b [3];
    logic signed [47:0] pe [3];
    logic signed [41:0] pb [3];
    logic [47:0]        c_e2;
    logic [41:0]        c_b2;
    cdv_pkg::t_fld      c_s1_fld;

    assign in_e[0] = i_e_x;
    assign in_e[1] = i_e_y;
    assign in_e[2] = i_e_z;
    assign in_b[0] = i_b_x;
    assign in_b[1] = i_b_y;
    assign in_b[2] = i_b_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pe[i] = in_e[i] * in_e[i];
            pb[i] = in_b[i] * in_b[i];
        end
        c_e2 = $unsigned(pe[0]) + $unsigned(pe[1]) + $unsigned(pe[2]);
        c_b2 = $unsigned(pb[0]) + $unsigned(pb[1]) + $unsigned(pb[2]);
        c_s1_fld      = '0;
        c_s1_fld.hole = i_action;
        c_s1_fld.lowf = (c_b2 < {10'd0, r_thr});
        for (int i = 0; i < 3; i++) begin
            c_s1_fld.e[i] = in_e[i];
            c_s1_fld.b[i] = in_b[i];
        end
    end

    logic          r_s1_v;
    cdv_pkg::t_fld r_s1_fld;
    logic [47:0]   r_s1_e2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_fld <= c_s1_fld;
            r_s1_e2  <= c_e2;
        end
    end

    // ------------------------------------------------------------------
    // |E| = isqrt(|E|^2 * 2^16): one root bit per cell
    // ------------------------------------------------------------------
    logic             sq_v    [0:cdv_pkg::ROOT_STEPS];
    logic [63:0]      sq_rad  [0:cdv_pkg::ROOT_STEPS];
    logic [34:0]      sq_rem  [0:cdv_pkg::ROOT_STEPS];
    logic [31:0]      sq_root [0:cdv_pkg::ROOT_STEPS];
    logic [FLD_W-1:0] sq_side [0:cdv_pkg::ROOT_STEPS];

    assign sq_v[0]    = r_s1_v;
    assign sq_rad[0]  = {r_s1_e2, 16'd0};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_s1_fld;

    for (genvar k = 0; k < cdv_pkg::ROOT_STEPS; k++) begin : g_sqrt
        cdv_sqrt_cell #(.SW(FLD_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // S2: mu0*|E| and mu0*vsat; S3: D = vsat + mu0*|E| / 2^16
    // ------------------------------------------------------------------
    cdv_pkg::t_fld sq_fld;
    cdv_pkg::t_fld c_s2_fld;
    logic [31:0]   s2_mu, s2_vs;

    assign sq_fld = sq_side[cdv_pkg::ROOT_STEPS];
    assign s2_mu  = sq_fld.hole ? r_mu_h : r_mu_e;
    assign s2_vs  = sq_fld.hole ? r_vs_h : r_vs_e;

    always_comb begin
        c_s2_fld     = sq_fld;
        c_s2_fld.vs0 = (s2_vs == 32'd0);
    end

    logic          r_s2_v;
    cdv_pkg::t_fld r_s2_fld;
    logic [63:0]   r_s2_prod, r_s2_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_fld  <= c_s2_fld;
            r_s2_prod <= s2_mu * sq_root[cdv_pkg::ROOT_STEPS];
            r_s2_num  <= s2_mu * s2_vs;
        end
    end

    logic [31:0] s3_vs;
    assign s3_vs = r_s2_fld.hole ? r_vs_h : r_vs_e;

    logic          r_s3_v;
    cdv_pkg::t_fld r_s3_fld;
    logic [48:0]   r_s3_d;
    logic [63:0]   r_s3_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_fld <= r_s2_fld;
            r_s3_d   <= {17'd0, s3_vs} + {1'b0, r_s2_prod[63:16]};
            r_s3_num <= r_s2_num;
        end
    end

    // ------------------------------------------------------------------
    // |mu| = mu0*vsat / D: one quotient bit per cell
    // ------------------------------------------------------------------
    logic             d1_v    [0:cdv_pkg::QUOT_STEPS];
    logic [48:0]      d1_div  [0:cdv_pkg::QUOT_STEPS];
    logic [48:0]      d1_rem  [0:cdv_pkg::QUOT_STEPS];
    logic [31:0]      d1_nq   [0:cdv_pkg::QUOT_STEPS];
    logic [FLD_W-1:0] d1_side [0:cdv_pkg::QUOT_STEPS];

    assign d1_v[0]    = r_s3_v;
    assign d1_div[0]  = r_s3_d;
    assign d1_rem[0]  = {17'd0, r_s3_num[63:32]};
    assign d1_nq[0]   = r_s3_num[31:0];
    assign d1_side[0] = r_s3_fld;

    for (genvar k = 0; k < cdv_pkg::QUOT_STEPS; k++) begin : g_div1
        cdv_div_cell #(.DW(49), .SW(FLD_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d1_v[k]),
            .i_div   (d1_div[k]),
            .i_rem   (d1_rem[k]),
            .i_nq    (d1_nq[k]),
            .i_side  (d1_side[k]),
            .o_valid (d1_v[k+1]),
            .o_div   (d1_div[k+1]),
            .o_rem   (d1_rem[k+1]),
            .o_nq    (d1_nq[k+1]),
            .o_side  (d1_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // H1: h = hf*mu / 2^16, low-field products mu*E
    // ------------------------------------------------------------------
    cdv_pkg::t_fld d1_fld;
    cdv_pkg::t_fld c_h1_fld;
    logic [17:0]   h1_hf;
    logic [49:0]   h1_hm;

    assign d1_fld = d1_side[cdv_pkg::QUOT_STEPS];

    always_comb begin
        c_h1_fld   = d1_fld;
        // zero saturation velocity gives zero mobility
        c_h1_fld.m = d1_fld.vs0 ? 32'd0 : d1_nq[cdv_pkg::QUOT_STEPS];
        h1_hf      = d1_fld.hole ? r_hf_h : r_hf_e;
        h1_hm      = h1_hf * c_h1_fld.m;
    end

    logic               r_h1_v;
    cdv_pkg::t_fld      r_h1_fld;
    logic [33:0]        r_h1_h;
    logic signed [56:0] r_h1_pl [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1_fld <= c_h1_fld;
            r_h1_h   <= h1_hm[49:16];
            for (int i = 0; i < 3; i++) begin
                r_h1_pl[i] <= $signed({1'b0, c_h1_fld.m}) * $signed(c_h1_fld.e[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // H2: h*B, round low-field velocity; H3: round g
    // ------------------------------------------------------------------
    logic signed [127:0] c_h2_vl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_h2_vl[i] = cdv_pkg::rnd_shr(128'(r_h1_pl[i]), 8);
        end
    end

    logic               r_h2_v;
    cdv_pkg::t_fld      r_h2_fld;
    logic signed [55:0] r_h2_pg [3];
    logic signed [48:0] r_h2_vl [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h2_fld <= r_h1_fld;
            for (int i = 0; i < 3; i++) begin
                r_h2_pg[i] <= $signed({1'b0, r_h1_h}) * $signed(r_h1_fld.b[i]);
                r_h2_vl[i] <= c_h2_vl[i][48:0];
            end
        end
    end

    logic signed [127:0] c_h3_g [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_h3_g[i] = cdv_pkg::rnd_shr(128'(r_h2_pg[i]), 16);
        end
    end

    logic               r_h3_v;
    cdv_pkg::t_fld      r_h3_fld;
    logic signed [39:0] r_h3_g  [3];
    logic signed [48:0] r_h3_vl [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h3_fld <= r_h2_fld;
            r_h3_vl  <= r_h2_vl;
            for (int i = 0; i < 3; i++) begin
                r_h3_g[i] <= c_h3_g[i][39:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // H4: g^2 in two halves and every E_j*g_k; H5: combine and round them
    // ------------------------------------------------------------------
    logic               r_h4_v;
    cdv_pkg::t_fld      r_h4_fld;
    logic signed [60:0] r_h4_gghi [3];
    logic signed [60:0] r_h4_gglo [3];
    logic signed [63:0] r_h4_eg [3][3];
    logic signed [48:0] r_h4_vl [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h4_fld <= r_h3_fld;
            r_h4_vl  <= r_h3_vl;
            for (int i = 0; i < 3; i++) begin
                r_h4_gghi[i] <= r_h3_g[i] * $signed(r_h3_g[i][39:20]);
                r_h4_gglo[i] <= r_h3_g[i] * $signed({1'b0, r_h3_g[i][19:0]});
                for (int k = 0; k < 3; k++) begin
                    r_h4_eg[i][k] <= $signed(r_h3_fld.e[i]) * r_h3_g[k];
                end
            end
        end
    end

    logic signed [127:0] c_h5_gq [3];
    logic signed [127:0] c_h5_t  [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_h5_gq[i] = cdv_pkg::rnd_shr((128'(r_h4_gghi[i]) <<< 20)
                                          + 128'(r_h4_gglo[i]), 48);
            for (int k = 0; k < 3; k++) begin
                c_h5_t[i][k] = cdv_pkg::rnd_shr(128'(r_h4_eg[i][k]), 8);
            end
        end
    end

    logic               r_h5_v;
    cdv_pkg::t_fld      r_h5_fld;
    logic [31:0]        r_h5_gq [3];
    logic signed [55:0] r_h5_t  [3][3];
    logic signed [48:0] r_h5_vl [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h5_fld <= r_h4_fld;
            r_h5_vl  <= r_h4_vl;
            for (int i = 0; i < 3; i++) begin
                r_h5_gq[i] <= c_h5_gq[i][31:0];
                for (int k = 0; k < 3; k++) begin
                    r_h5_t[i][k] <= c_h5_t[i][k][55:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // H6: denominator 1 + |g|^2, cross product E x g, dot product E.g
    // ------------------------------------------------------------------
    logic               r_h6_v;
    cdv_pkg::t_fld      r_h6_fld;
    logic [33:0]        r_h6_den;
    logic signed [55:0] r_h6_cr [3];
    logic signed [55:0] r_h6_eg;
    logic signed [48:0] r_h6_vl [3];
    logic signed [39:0] r_h6_g  [3];
    logic signed [39:0] r_h5_g  [3];
    logic signed [39:0] r_h4_g  [3];

    // carry g alongside H4, H5 and H6
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h4_g <= r_h3_g;
            r_h5_g <= r_h4_g;
            r_h6_g <= r_h5_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h6_fld  <= r_h5_fld;
            r_h6_vl   <= r_h5_vl;
            r_h6_den  <= 34'h1_0000_0000 + {2'd0, r_h5_gq[0]} + {2'd0, r_h5_gq[1]}
                         + {2'd0, r_h5_gq[2]};
            r_h6_cr[0] <= r_h5_t[1][2] - r_h5_t[2][1];
            r_h6_cr[1] <= r_h5_t[2][0] - r_h5_t[0][2];
            r_h6_cr[2] <= r_h5_t[0][1] - r_h5_t[1][0];
            r_h6_eg    <= r_h5_t[0][0] + r_h5_t[1][1] + r_h5_t[2][2];
        end
    end

    // ------------------------------------------------------------------
    // H7..H9: parallel term round(g*(E.g) / 2^40), split in two halves
    // ------------------------------------------------------------------
    logic               r_h7_v;
    cdv_pkg::t_fld      r_h7_fld;
    logic [33:0]        r_h7_den;
    logic signed [55:0] r_h7_cr  [3];
    logic signed [48:0] r_h7_vl  [3];
    logic signed [68:0] r_h7_plo [3];
    logic signed [67:0] r_h7_phi [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h7_fld <= r_h6_fld;
            r_h7_den <= r_h6_den;
            r_h7_cr  <= r_h6_cr;
            r_h7_vl  <= r_h6_vl;
            for (int i = 0; i < 3; i++) begin
                r_h7_plo[i] <= r_h6_g[i] * $signed({1'b0, r_h6_eg[27:0]});
                r_h7_phi[i] <= r_h6_g[i] * $signed(r_h6_eg[55:28]);
            end
        end
    end

    logic               r_h8_v;
    cdv_pkg::t_fld      r_h8_fld;
    logic [33:0]        r_h8_den;
    logic signed [55:0] r_h8_cr [3];
    logic signed [48:0] r_h8_vl [3];
    logic signed [95:0] r_h8_p  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h8_fld <= r_h7_fld;
            r_h8_den <= r_h7_den;
            r_h8_cr  <= r_h7_cr;
            r_h8_vl  <= r_h7_vl;
            for (int i = 0; i < 3; i++) begin
                r_h8_p[i] <= (96'(r_h7_phi[i]) <<< 28) + 96'(r_h7_plo[i]);
            end
        end
    end

    logic signed [127:0] c_h9_par [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_h9_par[i] = cdv_pkg::rnd_shr(128'(r_h8_p[i]), 40);
        end
    end

    logic               r_h9_v;
    cdv_pkg::t_fld      r_h9_fld;
    logic [33:0]        r_h9_den;
    logic signed [55:0] r_h9_cr  [3];
    logic signed [48:0] r_h9_vl  [3];
    logic signed [55:0] r_h9_par [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h9_fld <= r_h8_fld;
            r_h9_den <= r_h8_den;
            r_h9_cr  <= r_h8_cr;
            r_h9_vl  <= r_h8_vl;
            for (int i = 0; i < 3; i++) begin
                r_h9_par[i] <= c_h9_par[i][55:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // H10: N = E*2^32 + s*(E x g) + parallel term; electrons flip the cross term
    // ------------------------------------------------------------------
    logic               r_h10_v;
    cdv_pkg::t_fld      r_h10_fld;
    logic [33:0]        r_h10_den;
    logic signed [48:0] r_h10_vl [3];
    logic signed [57:0] r_h10_nv [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h10_fld <= r_h9_fld;
            r_h10_den <= r_h9_den;
            r_h10_vl  <= r_h9_vl;
            for (int i = 0; i < 3; i++) begin
                r_h10_nv[i] <= (58'($signed(r_h9_fld.e[i])) <<< 32)
                             + (r_h9_fld.hole ? 58'(r_h9_cr[i]) : -58'(r_h9_cr[i]))
                             + 58'(r_h9_par[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // f = |mu|*2^32 / den: one quotient bit per cell
    // ------------------------------------------------------------------
    cdv_pkg::t_d2_side c_d2_in;

    always_comb begin
        c_d2_in.fld = r_h10_fld;
        for (int i = 0; i < 3; i++) begin
            c_d2_in.vl[i] = r_h10_vl[i];
            c_d2_in.nv[i] = r_h10_nv[i];
        end
    end

    logic            d2_v    [0:cdv_pkg::QUOT_STEPS];
    logic [33:0]     d2_div  [0:cdv_pkg::QUOT_STEPS];
    logic [33:0]     d2_rem  [0:cdv_pkg::QUOT_STEPS];
    logic [31:0]     d2_nq   [0:cdv_pkg::QUOT_STEPS];
    logic [D2_W-1:0] d2_side [0:cdv_pkg::QUOT_STEPS];

    assign d2_v[0]    = r_h10_v;
    assign d2_div[0]  = r_h10_den;
    assign d2_rem[0]  = {2'd0, r_h10_fld.m};
    assign d2_nq[0]   = '0;
    assign d2_side[0] = c_d2_in;

    for (genvar k = 0; k < cdv_pkg::QUOT_STEPS; k++) begin : g_div2
        cdv_div_cell #(.DW(34), .SW(D2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d2_v[k]),
            .i_div   (d2_div[k]),
            .i_rem   (d2_rem[k]),
            .i_nq    (d2_nq[k]),
            .i_side  (d2_side[k]),
            .o_valid (d2_v[k+1]),
            .o_div   (d2_div[k+1]),
            .o_rem   (d2_rem[k+1]),
            .o_nq    (d2_nq[k+1]),
            .o_side  (d2_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // F1..F3: v = round(f*N / 2^40), split in two halves, pick low-field result
    // ------------------------------------------------------------------
    cdv_pkg::t_d2_side d2_out;
    logic [31:0]       d2_f;

    assign d2_out = d2_side[cdv_pkg::QUOT_STEPS];
    assign d2_f   = d2_nq[cdv_pkg::QUOT_STEPS];

    logic               r_f1_v;
    logic               r_f1_hole, r_f1_lowf;
    logic signed [48:0] r_f1_vl  [3];
    logic signed [62:0] r_f1_plo [3];
    logic signed [61:0] r_f1_phi [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_hole <= d2_out.fld.hole;
            r_f1_lowf <= d2_out.fld.lowf;
            for (int i = 0; i < 3; i++) begin
                r_f1_vl[i]  <= d2_out.vl[i];
                r_f1_plo[i] <= $signed({1'b0, d2_f}) * $signed({1'b0, d2_out.nv[i][28:0]});
                r_f1_phi[i] <= $signed({1'b0, d2_f}) * $signed(d2_out.nv[i][57:29]);
            end
        end
    end

    logic               r_f2_v;
    logic               r_f2_hole, r_f2_lowf;
    logic signed [48:0] r_f2_vl [3];
    logic signed [95:0] r_f2_p  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_hole <= r_f1_hole;
            r_f2_lowf <= r_f1_lowf;
            r_f2_vl   <= r_f1_vl;
            for (int i = 0; i < 3; i++) begin
                r_f2_p[i] <= (96'(r_f1_phi[i]) <<< 29) + 96'(r_f1_plo[i]);
            end
        end
    end

    logic signed [127:0] c_f3_v [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_f3_v[i] = cdv_pkg::rnd_shr(128'(r_f2_p[i]), 40);
        end
    end

    logic               r_f3_v;
    logic               r_f3_hole;
    logic signed [49:0] r_f3_vel [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_hole <= r_f2_hole;
            for (int i = 0; i < 3; i++) begin
                r_f3_vel[i] <= r_f2_lowf ? 50'(r_f2_vl[i]) : c_f3_v[i][49:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // F4: apply carrier sign, clamp to the 40-bit range
    // ------------------------------------------------------------------
    logic signed [50:0] c_f4_s   [3];
    logic signed [39:0] c_f4_vel [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_f4_s[i] = r_f3_hole ? 51'(r_f3_vel[i]) : -51'(r_f3_vel[i]);
            if (c_f4_s[i] > 51'(cdv_pkg::VEL_MAX)) begin
                c_f4_vel[i] = cdv_pkg::VEL_MAX;
            end else if (c_f4_s[i] < 51'(cdv_pkg::VEL_MIN)) begin
                c_f4_vel[i] = cdv_pkg::VEL_MIN;
            end else begin
                c_f4_vel[i] = c_f4_s[i][39:0];
            end
        end
    end

    logic               r_f4_v;
    logic signed [39:0] r_f4_vel [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f4_vel <= c_f4_vel;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of the stage registers outside the cell rows
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_h1_v  <= 1'b0;
            r_h2_v  <= 1'b0;
            r_h3_v  <= 1'b0;
            r_h4_v  <= 1'b0;
            r_h5_v  <= 1'b0;
            r_h6_v  <= 1'b0;
            r_h7_v  <= 1'b0;
            r_h8_v  <= 1'b0;
            r_h9_v  <= 1'b0;
            r_h10_v <= 1'b0;
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_f3_v  <= 1'b0;
            r_f4_v  <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= sq_v[cdv_pkg::ROOT_STEPS];
            r_s3_v  <= r_s2_v;
            r_h1_v  <= d1_v[cdv_pkg::QUOT_STEPS];
            r_h2_v  <= r_h1_v;
            r_h3_v  <= r_h2_v;
            r_h4_v  <= r_h3_v;
            r_h5_v  <= r_h4_v;
            r_h6_v  <= r_h5_v;
            r_h7_v  <= r_h6_v;
            r_h8_v  <= r_h7_v;
            r_h9_v  <= r_h8_v;
            r_h10_v <= r_h9_v;
            r_f1_v  <= d2_v[cdv_pkg::QUOT_STEPS];
            r_f2_v  <= r_f1_v;
            r_f3_v  <= r_f2_v;
            r_f4_v  <= r_f3_v;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic               r_oval;
    logic signed [39:0] r_out  [3];
    logic signed [39:0] r_skid [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval      <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            // drain the skid beat into the output register
            if (!i_stall) begin
                r_skid_full <= 1'b0;
            end
        end else if (r_f4_v) begin
            if (!r_oval || !i_stall) begin
                r_oval <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (r_f4_v) begin
            if (!r_oval || !i_stall) begin
                r_out <= r_f4_vel;
            end else begin
                r_skid <= r_f4_vel;
            end
        end
    end

    assign o_valid = r_oval;
    assign o_vel_x = r_out[0];
    assign o_vel_y = r_out[1];
    assign o_vel_z = r_out[2];

endmodule

`default_nettype wire

// File: src/cdv_checker.sv
`default_nettype none

module cdv_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          i_action,
    input wire logic signed [23:0]            i_e_x,
    input wire logic signed [23:0]            i_e_y,
    input wire logic signed [23:0]            i_e_z,
    input wire logic signed [20:0]            i_b_x,
    input wire logic signed [20:0]            i_b_y,
    input wire logic signed [20:0]            i_b_z,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic signed [39:0]            o_vel_x,
    input wire logic signed [39:0]            o_vel_y,
    input wire logic signed [39:0]            o_vel_z,
    input wire logic                          i_cfg_valid,
    input wire logic                          o_cfg_ready,
    input wire logic [cdv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [31:0]                   i_cfg_data
);

    // A stalled output beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped under stall");

    // A stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_vel_x) && $stable(o_vel_y) && $stable(o_vel_z))
        else $error("output payload changed under stall");

    // The input side only stalls once a beat waited on a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a waiting output beat");

    // A full skid register implies a beat is on show
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid register full with empty output");

    // Reset empties the output and skid registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

endmodule

bind carrier_drift_velocity cdv_checker u_cdv_checker (.*);

`default_nettype wire
